// File: hdl/sba_pkg.sv
package sba_pkg;

    localparam int NUM_SLABS_DEF   = 8;
    localparam int MAX_OBJECTS_DEF = 32;
    localparam int CFG_DATA_W      = 13;
    localparam int CFG_IDX_W       = 2;
    localparam int HANDLE_W        = 8;
    localparam int ADDR_W          = 20;
    localparam int STATUS_W        = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_OBJECTS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXEMPTY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

    typedef enum logic [1:0] {
        K_UNUSED  = 2'd0,
        K_PARTIAL = 2'd1,
        K_FULL    = 2'd2,
        K_EMPTY   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_UNLINK,
        S_MUL,
        S_DONE
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic start;    // latch the input word
        logic decide;   // choose slab / validate free
        logic scan;     // find bit and update slab
        logic unlink;   // one walk step of an unlink
        logic mul;      // address multiply
        logic finish;   // load output register
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic fail;        // result already decided as an error
        logic need_unlink; // a list walk is pending
        logic unlink_done;
    } t_stat;

endpackage

// File: hdl/sba_if.sv
interface sba_if #(parameter int W = 1) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/sba_ctrl.sv
module sba_ctrl
    import sba_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_full,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = i_stat.fail ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.fail) begin
                    n_state = S_DONE;
                end else if (i_stat.need_unlink) begin
                    n_state = S_UNLINK;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_UNLINK: begin
                if (i_stat.unlink_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_out_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.start  = i_in_valid;
            end
            S_DECIDE: o_cmd.decide = 1'b1;
            S_SCAN:   o_cmd.scan   = 1'b1;
            S_UNLINK: o_cmd.unlink = 1'b1;
            S_MUL:    o_cmd.mul    = 1'b1;
            S_DONE:   o_cmd.finish = !i_out_full;
            default: begin
            end
        endcase
    end

endmodule

// File: hdl/sba_dp.sv
module sba_dp
    import sba_pkg::*;
#(
    parameter int NUM_SLABS   = NUM_SLABS_DEF,
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_in_op,
    input  logic [HANDLE_W-1:0]   i_in_handle,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [STATUS_W-1:0]   o_status,
    output logic [HANDLE_W-1:0]   o_handle,
    output logic [ADDR_W-1:0]     o_addr
);

    localparam int SW = $clog2(NUM_SLABS + 1);           // link width incl. null
    localparam int SI = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
    localparam int OW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CW = $clog2(MAX_OBJECTS + 1);
    localparam logic [SW-1:0] LNULL = SW'(NUM_SLABS);

    // List that an unlink walks.
    localparam logic [1:0] UL_PARTIAL = 2'd0;
    localparam logic [1:0] UL_FULL    = 2'd1;

    // Move that follows an unlink.
    localparam logic [1:0] POST_NONE       = 2'd0;
    localparam logic [1:0] POST_TO_FULL    = 2'd1;
    localparam logic [1:0] POST_TO_PARTIAL = 2'd2;
    localparam logic [1:0] POST_RETIRE     = 2'd3;

    // Configuration.
    logic [5:0]  r_ops_cfg;
    logic [12:0] r_bytes_cfg;
    logic [3:0]  r_max_empty;
    logic        pool_clear;

    assign pool_clear = i_cfg_we && (i_cfg_idx == CFG_OBJECTS || i_cfg_idx == CFG_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ops_cfg   <= 6'd32;
            r_bytes_cfg <= 13'd8;
            r_max_empty <= 4'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OBJECTS:  r_ops_cfg   <= i_cfg_data[5:0];
                CFG_BYTES:    r_bytes_cfg <= i_cfg_data;
                CFG_MAXEMPTY: r_max_empty <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    logic [CW-1:0] eff_ops;
    logic [13:0]   eff_size;
    always_comb begin
        if (r_ops_cfg == 6'd0) begin
            eff_ops = CW'(1);
        end else if (32'(r_ops_cfg) > MAX_OBJECTS) begin
            eff_ops = CW'(MAX_OBJECTS);
        end else begin
            eff_ops = CW'(r_ops_cfg);
        end
        eff_size = ((r_bytes_cfg == 13'd0) ? 14'd8 : ({1'b0, r_bytes_cfg} + 14'd7)) & ~14'd7;
    end

    // Slab state.
    logic [MAX_OBJECTS-1:0] r_bmp  [NUM_SLABS];
    logic [CW-1:0]          r_cnt  [NUM_SLABS];
    t_kind                  r_kind [NUM_SLABS];
    logic [SW-1:0]          r_link [NUM_SLABS];
    logic [SW-1:0]          r_ph, r_fh, r_eh;
    logic [3:0]             r_ecnt;

    // Work registers.
    logic                r_op;
    logic [HANDLE_W-1:0] r_h;
    logic [SI-1:0]       r_s;
    logic [OW-1:0]       r_idx;
    logic                r_fail;
    logic [STATUS_W-1:0] r_st;
    logic                r_need_ul;
    logic [1:0]          r_ul_list;   // which head to unlink from
    logic [SW-1:0]       r_cur;
    logic                r_ul_first;
    logic [ADDR_W-1:0]   r_lin;       // slab*ops
    logic [ADDR_W-1:0]   r_addr_w;
    logic [1:0]          r_post;

    // Decode of a free handle.
    logic [HANDLE_W-1:0] h_slab;
    logic [OW-1:0]       h_idx;
    assign h_slab = HANDLE_W'(r_h / MAX_OBJECTS);
    assign h_idx  = OW'(r_h % MAX_OBJECTS);

    // Lowest unused slab.
    logic          unused_found;
    logic [SI-1:0] unused_s;
    always_comb begin
        unused_found = 1'b0;
        unused_s     = '0;
        for (int k = NUM_SLABS - 1; k >= 0; k--) begin
            if (r_kind[k] == K_UNUSED) begin
                unused_found = 1'b1;
                unused_s     = SI'(k);
            end
        end
    end

    // Lowest clear bit within eff_ops of the chosen slab.
    logic          bit_found;
    logic [OW-1:0] bit_idx;
    always_comb begin
        bit_found = 1'b0;
        bit_idx   = '0;
        for (int k = MAX_OBJECTS - 1; k >= 0; k--) begin
            if (k < int'(eff_ops) && !r_bmp[r_s][k]) begin
                bit_found = 1'b1;
                bit_idx   = OW'(k);
            end
        end
    end

    // The scan step already knows whether the slab will change lists.
    logic scan_need_ul;
    always_comb begin
        if (!r_op) begin
            scan_need_ul = bit_found && ((r_cnt[r_s] + CW'(1)) >= eff_ops);
        end else begin
            scan_need_ul = (r_cnt[r_s] <= CW'(1)) || (r_kind[r_s] == K_FULL);
        end
    end

    logic [SW-1:0] ul_head;
    always_comb begin
        case (r_ul_list)
            UL_PARTIAL: ul_head = r_ph;
            default:    ul_head = r_fh;
        endcase
    end

    logic [SW-1:0] s_ext;
    assign s_ext = SW'(r_s);

    logic ul_hit;
    logic ul_end;
    assign ul_hit = r_ul_first ? (ul_head == s_ext)
                  : (r_cur != LNULL && r_link[SI'(r_cur)] == s_ext);
    assign ul_end = !r_ul_first && (r_cur == LNULL);

    logic dec_fail;

    assign o_stat.fail        = i_cmd.decide ? dec_fail : r_fail;
    assign o_stat.need_unlink = i_cmd.scan ? scan_need_ul : r_need_ul;
    assign o_stat.unlink_done = ul_hit || ul_end;

    always_comb begin
        dec_fail = 1'b0;
        if (r_op) begin
            if (32'(h_slab) >= NUM_SLABS) begin
                dec_fail = 1'b1;
            end else if (r_kind[SI'(h_slab)] != K_PARTIAL && r_kind[SI'(h_slab)] != K_FULL) begin
                dec_fail = 1'b1;
            end else if (32'(h_idx) >= int'(eff_ops)) begin
                dec_fail = 1'b1;
            end else if (!r_bmp[SI'(h_slab)][h_idx]) begin
                dec_fail = 1'b1;
            end
        end else if (r_ph == LNULL && r_eh == LNULL && !unused_found) begin
            dec_fail = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || pool_clear) begin
            for (int k = 0; k < NUM_SLABS; k++) begin
                r_cnt[k]  <= '0;
                r_kind[k] <= K_UNUSED;
                r_link[k] <= LNULL;
            end
            r_ph      <= LNULL;
            r_fh      <= LNULL;
            r_eh      <= LNULL;
            r_ecnt    <= '0;
            r_fail    <= 1'b0;
            r_need_ul <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_op      <= i_in_op;
                r_h       <= i_in_handle;
                r_fail    <= 1'b0;
                r_need_ul <= 1'b0;
                r_post    <= POST_NONE;
            end
            if (i_cmd.decide) begin
                r_fail <= dec_fail;
                r_st   <= r_op ? ST_REJECT : ST_OOM;
                if (r_op) begin
                    r_s   <= SI'(h_slab);
                    r_idx <= h_idx;
                end else if (!dec_fail) begin
                    if (r_ph != LNULL) begin
                        r_s <= SI'(r_ph);
                    end else if (r_eh != LNULL) begin
                        r_s                <= SI'(r_eh);
                        r_eh               <= r_link[SI'(r_eh)];
                        if (r_ecnt != 4'd0) r_ecnt <= r_ecnt - 4'd1;
                        r_kind[SI'(r_eh)]  <= K_PARTIAL;
                        r_link[SI'(r_eh)]  <= r_ph;
                        r_ph               <= r_eh;
                    end else begin
                        r_s                <= unused_s;
                        r_bmp[unused_s]    <= '0;
                        r_cnt[unused_s]    <= '0;
                        r_kind[unused_s]   <= K_PARTIAL;
                        r_link[unused_s]   <= r_ph;
                        r_ph               <= SW'(unused_s);
                    end
                end
            end
            if (i_cmd.scan) begin
                r_ul_first <= 1'b1;
                r_cur      <= LNULL;
                if (!r_op) begin
                    if (!bit_found) begin
                        r_fail <= 1'b1;
                    end else begin
                        r_idx            <= bit_idx;
                        r_bmp[r_s][bit_idx] <= 1'b1;
                        r_cnt[r_s]       <= r_cnt[r_s] + CW'(1);
                        if (r_cnt[r_s] + CW'(1) >= eff_ops) begin
                            r_need_ul <= 1'b1;
                            r_ul_list <= UL_PARTIAL;
                            r_post    <= POST_TO_FULL;
                        end
                    end
                end else begin
                    r_bmp[r_s][r_idx] <= 1'b0;
                    if (r_cnt[r_s] != '0) r_cnt[r_s] <= r_cnt[r_s] - CW'(1);
                    if (r_cnt[r_s] <= CW'(1)) begin
                        r_need_ul <= 1'b1;
                        r_ul_list <= (r_kind[r_s] == K_FULL) ? UL_FULL : UL_PARTIAL;
                        r_post    <= POST_RETIRE;
                    end else if (r_kind[r_s] == K_FULL) begin
                        r_need_ul <= 1'b1;
                        r_ul_list <= UL_FULL;
                        r_post    <= POST_TO_PARTIAL;
                    end
                end
                r_lin <= ADDR_W'(r_s) * ADDR_W'(eff_ops);
            end
            if (i_cmd.unlink) begin
                r_ul_first <= 1'b0;
                if (r_ul_first) begin
                    r_cur <= ul_head;
                    if (ul_hit) begin
                        if (r_ul_list == UL_PARTIAL) r_ph <= r_link[r_s];
                        else                         r_fh <= r_link[r_s];
                    end
                end else if (!ul_end) begin
                    r_cur <= r_link[SI'(r_cur)];
                    if (ul_hit) r_link[SI'(r_cur)] <= r_link[r_s];
                end
                if (ul_hit || ul_end) begin
                    r_need_ul <= 1'b0;
                    case (r_post)
                        POST_TO_FULL: begin
                            r_kind[r_s] <= K_FULL;
                            r_link[r_s] <= r_fh;
                            r_fh        <= s_ext;
                        end
                        POST_TO_PARTIAL: begin
                            r_kind[r_s] <= K_PARTIAL;
                            r_link[r_s] <= r_ph;
                            r_ph        <= s_ext;
                        end
                        POST_RETIRE: begin
                            if (r_ecnt < r_max_empty) begin
                                r_kind[r_s] <= K_EMPTY;
                                r_link[r_s] <= r_eh;
                                r_eh        <= s_ext;
                                r_ecnt      <= r_ecnt + 4'd1;
                            end else begin
                                r_kind[r_s] <= K_UNUSED;
                                r_link[r_s] <= LNULL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            if (i_cmd.mul) begin
                r_st     <= ST_OK;
                r_addr_w <= ADDR_W'((r_lin + ADDR_W'(r_idx)) * ADDR_W'(eff_size));
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_status <= r_st;
            if (r_st == ST_OK && !r_op) begin
                o_handle <= HANDLE_W'(r_s * MAX_OBJECTS + int'(r_idx));
                o_addr   <= r_addr_w;
            end else begin
                o_handle <= '0;
                o_addr   <= '0;
            end
        end
    end

endmodule

// File: hdl/slab_bitmap_allocator.sv
// Slab bitmap allocator.
// Requests arrive on in_if: operation 0 allocates an object, 1 frees the
// object named by object_handle. Every request word yields exactly one
// result word on out_if with status, granted handle and object address.
// Each word is finished before the next is taken. A failing request goes
// through the decide step, and for an allocation maybe the scan step, to
// its result. A successful one goes through the decide, scan and multiply
// steps, plus an unlink walk when a slab changes list that checks the list
// head and then goes one link per cycle along the singly linked list.
// The result sits in an output register; while the receiver stalls, the
// block finishes the current request, waits with its result and accepts no
// new word until it is stored. Configuration writes go through the plain
// write port; the user must issue them only while the block is idle, which
// the block does not enforce. Writing the slab capacity or the object size
// empties the pool in the same cycle. Synchronous reset returns all slabs to
// the unused state and the configuration registers to their default values.
module slab_bitmap_allocator
    import sba_pkg::*;
#(
    parameter int NUM_SLABS   = NUM_SLABS_DEF,
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sba_if.sink                   in_if,
    sba_if.source                 out_if,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;
    logic  r_out_valid;
    logic  in_ready;

    logic [STATUS_W-1:0] st;
    logic [HANDLE_W-1:0] hd;
    logic [ADDR_W-1:0]   ad;

    // The output word is full until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (out_if.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    sba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_if.valid),
        .o_in_ready (in_ready),
        .i_out_full (r_out_valid && !out_if.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sba_dp #(
        .NUM_SLABS   (NUM_SLABS),
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_op     (in_if.data[HANDLE_W]),
        .i_in_handle (in_if.data[HANDLE_W-1:0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_status    (st),
        .o_handle    (hd),
        .o_addr      (ad)
    );

    assign in_if.ready  = in_ready;
    assign out_if.valid = r_out_valid;
    assign out_if.data  = {st, hd, ad};

endmodule
